// ===== hw/rtl/multi_encoding_char_decoder_top_defines.svh =====
// Assertion macros for the character decoder.
`ifndef MULTI_ENCODING_CHAR_DECODER_TOP_DEFINES_SVH
`define MULTI_ENCODING_CHAR_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check prop on every rising edge of clk, outside reset.
`define MECD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that cond never holds, outside reset.
`define MECD_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MECD_ASSERT(label, clk, rst, prop, msg)
`define MECD_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// ===== hw/rtl/mecd_pkg.sv =====
package mecd_pkg;

  typedef enum logic [1:0] {
    MODE_UTF8    = 2'd0,
    MODE_UTF16BE = 2'd1,
    MODE_CP1252  = 2'd2,
    MODE_SJIS    = 2'd3
  } mode_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] code;
    logic [1:0]  used;
  } result_t;

  // Shift-JIS double-byte lead: 0x81..0x9F or 0xE0..0xFF
  function automatic logic sjis_lead(input logic [7:0] b);
    return ((b >= 8'h81) && (b < 8'hA0)) || (b >= 8'hE0);
  endfunction

endpackage

// ===== hw/rtl/multi_encoding_char_decoder_top.sv =====
// Character stream decoder: one raw byte per request in, one 16-bit character
// code per completed character out.
// Input channel: stream_valid / stream_stall carry stream_byte. A byte is taken
// at a rising edge with stream_valid high and stream_stall low.
// Output channel: char_valid / char_stall carry char_code and bytes_used (1..3).
// The encoding is set through encoding_mode_we / encoding_mode_wdata
// (0 UTF-8, 1 UTF-16 big-endian, 2 CP1252, 3 Shift-JIS); a write drops any
// partly collected character. Write it only while the decoder is idle.
// Throughput: one byte per cycle while stream_stall is low. A completed character
// is registered into the output register, or into the skid register while the receiver holds it.
// Results sit in an output register backed by one skid register, so a byte is
// still taken while the receiver stalls; stream_stall rises only once the skid
// register holds a result as well, and falls when the receiver drains it.
// Reset (rst, synchronous) selects UTF-8, clears the partial character and
// empties both result registers.
`include "multi_encoding_char_decoder_top_defines.svh"

module multi_encoding_char_decoder_top
  import mecd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        encoding_mode_we,
  input  logic [1:0]  encoding_mode_wdata,
  input  logic        stream_valid,
  output logic        stream_stall,
  input  logic [7:0]  stream_byte,
  output logic        char_valid,
  input  logic        char_stall,
  output logic [15:0] char_code,
  output logic [1:0]  bytes_used
);

  mode_t       mode;
  logic [1:0]  bytes_pending;
  logic [15:0] partial_code;
  logic [1:0]  bytes_taken;

  logic [1:0]  bytes_pending_next;
  logic [15:0] partial_code_next;
  logic [1:0]  bytes_taken_next;
  result_t     res;

  logic        skid_valid;
  logic [15:0] skid_code;
  logic [1:0]  skid_used;

  logic        accept;
  logic        out_take;

  assign stream_stall = skid_valid;
  assign accept       = stream_valid && !skid_valid;
  assign out_take     = char_valid && !char_stall;

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_code_next  = partial_code;
    bytes_taken_next   = bytes_taken;
    res                = '0;
    if (bytes_pending == 2'd0) begin
      // lead byte: start a character or finish a single-byte one
      bytes_taken_next  = 2'd1;
      partial_code_next = {8'h00, stream_byte};
      res.code          = {8'h00, stream_byte};
      res.used          = 2'd1;
      unique case (mode)
        MODE_UTF8: begin
          if (!stream_byte[7]) begin
            res.valid = 1'b1;
          end else if (stream_byte[7:5] == 3'b110) begin
            bytes_pending_next = 2'd1;
            partial_code_next  = {11'h000, stream_byte[4:0]};
          end else begin
            bytes_pending_next = 2'd2;
            partial_code_next  = {12'h000, stream_byte[3:0]};
          end
        end
        MODE_UTF16BE: bytes_pending_next = 2'd1;
        MODE_CP1252:  res.valid = 1'b1;
        MODE_SJIS: begin
          if (sjis_lead(stream_byte)) begin
            bytes_pending_next = 2'd1;
          end else begin
            res.valid = 1'b1;
          end
        end
        default: res.valid = 1'b1;
      endcase
      if (res.valid) begin
        bytes_taken_next  = 2'd0;
        partial_code_next = '0;
      end
    end else begin
      // continuation byte: only the low six bits count in UTF-8
      if (mode == MODE_UTF8) begin
        res.code = {partial_code[9:0], stream_byte[5:0]};
      end else begin
        res.code = {partial_code[7:0], stream_byte};
      end
      res.used           = bytes_taken + 2'd1;
      bytes_pending_next = bytes_pending - 2'd1;
      bytes_taken_next   = res.used;
      partial_code_next  = res.code;
      if (bytes_pending == 2'd1) begin
        res.valid         = 1'b1;
        bytes_taken_next  = 2'd0;
        partial_code_next = '0;
      end
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_UTF8;
      bytes_pending <= '0;
      partial_code  <= '0;
      bytes_taken   <= '0;
    end else if (encoding_mode_we) begin
      mode          <= mode_t'(encoding_mode_wdata);
      bytes_pending <= '0;
      partial_code  <= '0;
      bytes_taken   <= '0;
    end else if (accept) begin
      bytes_pending <= bytes_pending_next;
      partial_code  <= partial_code_next;
      bytes_taken   <= bytes_taken_next;
    end
  end

  // output register and skid register, control
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept && res.valid) begin
      if (char_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        char_valid <= 1'b1;
      end
    end else if (out_take) begin
      char_valid <= 1'b0;
    end
  end

  // output register and skid register, payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        char_code  <= skid_code;
        bytes_used <= skid_used;
      end
    end else if (accept && res.valid) begin
      if (char_valid && !out_take) begin
        skid_code <= res.code;
        skid_used <= res.used;
      end else begin
        char_code  <= res.code;
        bytes_used <= res.used;
      end
    end
  end

  `MECD_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> char_valid, "skid full, output empty")
  `MECD_ASSERT(a_skid_holds, clk, rst, (skid_valid && !out_take) |=> skid_valid, "skid lost result")
  `MECD_ASSERT(a_used_nonzero, clk, rst, char_valid |-> (bytes_used != 2'd0), "zero bytes_used")
  `MECD_ASSERT(a_taken_consistent, clk, rst, (bytes_pending != 2'd0) |-> (bytes_taken != 2'd0), "pending with none taken")
  `MECD_NEVER(a_three_byte_utf8_only, clk, rst, (bytes_pending == 2'd2) && (mode != MODE_UTF8), "two pending outside UTF-8")

endmodule

// ===== bench/multi_encoding_char_decoder_checker.sv =====
`timescale 1ns / 1ps

module multi_encoding_char_decoder_checker
  import mecd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        encoding_mode_we,
  input  logic [1:0]  encoding_mode_wdata,
  input  logic        stream_valid,
  input  logic        stream_stall,
  input  logic [7:0]  stream_byte,
  input  logic        char_valid,
  input  logic        char_stall,
  input  logic [15:0] char_code,
  input  logic [1:0]  bytes_used,
  output int          error_count,
  output int          chars_due,
  output int          chars_checked
);

  typedef struct packed {
    logic [15:0] code;
    logic [1:0]  used;
  } char_rec_t;

  mode_t       cur_mode;
  logic [1:0]  need_left;
  logic [15:0] acc_code;
  logic [1:0]  got_bytes;
  char_rec_t   due_q[$];
  int          n_err = 0;
  int          n_checked = 0;

  assign error_count   = n_err;
  assign chars_checked = n_checked;

  initial chars_due = 0;

  task automatic report(input string what);
    n_err++;
    $display("[%0t] char check: %s", $time, what);
  endtask

  function automatic void drop_char();
    need_left = 2'd0;
    acc_code  = 16'h0000;
    got_bytes = 2'd0;
  endfunction

  // Advance the decode state by one byte; returns 1 when a character completes.
  function automatic logic decode_byte(input logic [7:0] b, output char_rec_t rec);
    logic [1:0] need;
    rec = '0;
    if (need_left == 2'd0) begin
      need     = 2'd0;
      acc_code = {8'h00, b};
      case (cur_mode)
        MODE_UTF8: begin
          if (b[7] == 1'b0) begin
            need = 2'd0;
          end else if (b[7:5] == 3'b110) begin
            need     = 2'd1;
            acc_code = {11'd0, b[4:0]};
          end else begin
            // anything else, a stray continuation too, opens a three-byte character
            need     = 2'd2;
            acc_code = {12'd0, b[3:0]};
          end
        end
        MODE_UTF16BE: need = 2'd1;
        MODE_SJIS: begin
          if ((b >= 8'h81 && b <= 8'h9F) || b >= 8'hE0) need = 2'd1;
        end
        default: need = 2'd0;
      endcase
      if (need == 2'd0) begin
        rec.code = acc_code;
        rec.used = 2'd1;
        drop_char();
        return 1'b1;
      end
      need_left = need;
      got_bytes = 2'd1;
      return 1'b0;
    end
    if (cur_mode == MODE_UTF8) acc_code = {acc_code[9:0], b[5:0]};
    else acc_code = {acc_code[7:0], b};
    got_bytes = got_bytes + 2'd1;
    need_left = need_left - 2'd1;
    if (need_left == 2'd0) begin
      rec.code = acc_code;
      rec.used = got_bytes;
      drop_char();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    char_rec_t rec;
    if (rst) begin
      cur_mode = MODE_UTF8;
      drop_char();
      due_q.delete();
    end else begin
      // a register write abandons any partial character
      if (encoding_mode_we) begin
        cur_mode = mode_t'(encoding_mode_wdata);
        drop_char();
      end
      if (stream_valid && !stream_stall && decode_byte(stream_byte, rec))
        due_q.push_back(rec);
      if (char_valid && !char_stall) begin
        if (due_q.size() == 0) begin
          report($sformatf("unexpected character code=%h used=%0d", char_code, bytes_used));
        end else begin
          rec = due_q.pop_front();
          n_checked++;
          if (char_code !== rec.code)
            report($sformatf("char_code %h, want %h", char_code, rec.code));
          if (bytes_used !== rec.used)
            report($sformatf("bytes_used %0d, want %0d (code %h)", bytes_used, rec.used,
                             rec.code));
        end
      end
    end
    chars_due <= due_q.size();
  end

endmodule

// ===== bench/multi_encoding_char_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module multi_encoding_char_decoder_top_tb;
  import mecd_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_BYTES  = 190;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        encoding_mode_we = 1'b0;
  logic [1:0]  encoding_mode_wdata = 2'd0;
  logic        stream_valid = 1'b0;
  logic        stream_stall;
  logic [7:0]  stream_byte = 8'h00;
  logic        char_valid;
  logic        char_stall = 1'b0;
  logic [15:0] char_code;
  logic [1:0]  bytes_used;

  int   n_errors;
  int   n_due;
  int   n_chars;
  int   bytes_sent = 0;
  int   burst_left = 0;
  int   mode_writes = 0;
  int   cycles = 0;
  logic hold_off_req = 1'b0;

  always #5 clk = ~clk;

  multi_encoding_char_decoder_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .encoding_mode_we    (encoding_mode_we),
    .encoding_mode_wdata (encoding_mode_wdata),
    .stream_valid        (stream_valid),
    .stream_stall        (stream_stall),
    .stream_byte         (stream_byte),
    .char_valid          (char_valid),
    .char_stall          (char_stall),
    .char_code           (char_code),
    .bytes_used          (bytes_used)
  );

  multi_encoding_char_decoder_checker u_check (
    .clk                 (clk),
    .rst                 (rst),
    .encoding_mode_we    (encoding_mode_we),
    .encoding_mode_wdata (encoding_mode_wdata),
    .stream_valid        (stream_valid),
    .stream_stall        (stream_stall),
    .stream_byte         (stream_byte),
    .char_valid          (char_valid),
    .char_stall          (char_stall),
    .char_code           (char_code),
    .bytes_used          (bytes_used),
    .error_count         (n_errors),
    .chars_due           (n_due),
    .chars_checked       (n_chars)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("multi_encoding_char_decoder_top_tb: done, errors");
      $finish;
    end
  end

  // Receiver: stall patterns of random length, plus one long hold-off on request.
  initial begin : rx_side
    int pat;
    int span;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        char_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pat  = $urandom_range(0, 3);
        span = $urandom_range(4, 50);
        repeat (span) begin
          case (pat)
            0:       char_stall <= 1'b0;
            1:       char_stall <= ($urandom_range(0, 3) == 0);
            2:       char_stall <= ($urandom_range(0, 3) != 0);
            default: char_stall <= ~char_stall;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Offer one byte and hold it until taken; idle between bursts.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    stream_byte  <= b;
    stream_valid <= 1'b1;
    @(posedge clk);
    while (stream_stall) @(posedge clk);
    bytes_sent++;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        stream_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    stream_valid <= 1'b0;
    @(posedge clk);
    while (n_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    drain();
    encoding_mode_we    <= 1'b1;
    encoding_mode_wdata <= m;
    @(posedge clk);
    encoding_mode_we <= 1'b0;
    mode_writes++;
  endtask

  function automatic logic [7:0] cont_byte();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
  endfunction

  // Send one whole character in the given encoding, now and then a stray byte instead.
  task automatic send_char(input mode_t m);
    logic [7:0] lead;
    if ($urandom_range(0, 9) == 0) begin
      push_byte(8'($urandom));
      return;
    end
    case (m)
      MODE_UTF8: begin
        case ($urandom_range(0, 2))
          0: push_byte({1'b0, 7'($urandom)});
          1: begin
            push_byte({3'b110, 5'($urandom)});
            push_byte(cont_byte());
          end
          default: begin
            case ($urandom_range(0, 5))
              0:       lead = {4'b1111, 4'($urandom)};
              1:       lead = {2'b10, 6'($urandom)};
              default: lead = {4'b1110, 4'($urandom)};
            endcase
            push_byte(lead);
            push_byte(cont_byte());
            push_byte(cont_byte());
          end
        endcase
      end
      MODE_UTF16BE: begin
        push_byte(8'($urandom));
        push_byte(8'($urandom));
      end
      MODE_SJIS: begin
        lead = 8'($urandom);
        push_byte(lead);
        if ((lead >= 8'h81 && lead <= 8'h9F) || lead >= 8'hE0) push_byte(8'($urandom));
      end
      default: push_byte(8'($urandom));
    endcase
  endtask

  initial begin : stimulus
    logic [7:0] seq[$];
    mode_t      plan[8];
    mode_t      m;
    int         target;
    plan = '{MODE_SJIS, MODE_UTF8, MODE_UTF16BE, MODE_CP1252,
             MODE_UTF8, MODE_SJIS, MODE_UTF16BE, MODE_UTF8};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes and the edge cases of each encoding; the last byte of
    // each set but the CP1252 one is left dangling so the next write must abandon it
    set_mode(MODE_UTF8);
    seq = '{8'h00, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'hEF, 8'hFF, 8'hFF,
            8'h80, 8'h00, 8'h3F, 8'hE1};
    foreach (seq[i]) push_byte(seq[i]);
    set_mode(MODE_UTF16BE);
    seq = '{8'hFF, 8'h00, 8'h12};
    foreach (seq[i]) push_byte(seq[i]);
    set_mode(MODE_CP1252);
    seq = '{8'h00, 8'hFF};
    foreach (seq[i]) push_byte(seq[i]);
    set_mode(MODE_SJIS);
    seq = '{8'h80, 8'h81, 8'h40, 8'h9F, 8'hFF, 8'hA0, 8'hDF, 8'hE0, 8'h00, 8'h81};
    foreach (seq[i]) push_byte(seq[i]);

    for (int p = 0; p < 8; p++) begin
      m = ($urandom_range(0, 3) == 0) ? mode_t'($urandom_range(0, 3)) : plan[p];
      set_mode(m);
      // hold the receiver off early on so the skid fills and the input stalls
      if (p == 0) hold_off_req = 1'b1;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_char(m);
    end
    drain();

    $display("Sent %0d stream bytes across %0d encoding writes, all four encodings.",
             bytes_sent, mode_writes);
    $display("Compared %0d decoded characters, %0d mismatches.", n_chars, n_errors);
    if (n_errors == 0) begin
      $display("multi_encoding_char_decoder_top_tb: done, clean");
    end else begin
      $display("multi_encoding_char_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
